// ===== rtl/pump_schedule_controller_defines.svh =====
// assertion macros for the pump schedule controller checker
// needs clk and rst_n in scope where the macros are used
`ifndef PUMP_SCHEDULE_CONTROLLER_DEFINES_SVH
`define PUMP_SCHEDULE_CONTROLLER_DEFINES_SVH

// same-cycle implication, masked during reset
`define PSC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pump schedule check failed");

// next-cycle implication, masked during reset
`define PSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pump schedule check failed");

`endif

// ===== rtl/psc_pkg.sv =====
// shared types and constants of the pump schedule controller
// no dependencies
package psc_pkg;

  localparam int HOURS_PER_DAY    = 24;
  localparam int MINUTES_PER_HOUR = 60;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [16:0] SINCE_MAX = 17'h1FFFF;

  // sequence codes
  localparam logic [2:0] SEQ_IDLE     = 3'd0;
  localparam logic [2:0] SEQ_PERIODIC = 3'd1;
  localparam logic [2:0] SEQ_WARMUP   = 3'd2;
  localparam logic [2:0] SEQ_ACTIVE   = 3'd3;
  localparam logic [2:0] SEQ_EXTENDED = 3'd4;

  // run modes
  localparam logic [1:0] RUN_AUTO = 2'd0;
  localparam logic [1:0] RUN_OFF  = 2'd1;
  localparam logic [1:0] RUN_ON   = 2'd2;

  // register indexes
  localparam logic [2:0] REG_RUN_MODE  = 3'd0;
  localparam logic [2:0] REG_AUTO_SRC  = 3'd1;
  localparam logic [2:0] REG_HOUR_PROG = 3'd2;
  localparam logic [2:0] REG_TPROG_0   = 3'd3;
  localparam logic [2:0] REG_TPROG_1   = 3'd4;
  localparam logic [2:0] REG_TPROG_2   = 3'd5;
  localparam logic [2:0] REG_TPROG_3   = 3'd6;
  localparam logic [2:0] REG_INTERVAL  = 3'd7;

  typedef struct packed {
    logic        start;
    logic [23:0] mask;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } prog_req_t;

  typedef struct packed {
    logic       done;
    logic [6:0] pct;
  } prog_rsp_t;

endpackage

// ===== rtl/psc_progress.sv =====
// progress unit: scans the hour mask one hour a cycle, then a restoring divide
// one quotient bit a cycle; uses psc_pkg
module psc_progress (
  input  logic                clk,
  input  logic                rst_n,
  input  psc_pkg::prog_req_t  req,
  output psc_pkg::prog_rsp_t  rsp
);
  import psc_pkg::*;

  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_SCAN = 3'd1;
  localparam logic [2:0] P_PREP = 3'd2;
  localparam logic [2:0] P_DIV  = 3'd3;
  localparam logic [2:0] P_DONE = 3'd4;

  logic [2:0]  phase_r, phase_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [23:0] mask_r, mask_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  minute_r, minute_nxt;
  logic [10:0] total_r, total_nxt;
  logic [10:0] acc_r, acc_nxt;
  logic [17:0] rem_r, rem_nxt;
  logic [16:0] div_r, div_nxt;
  logic [6:0]  quo_r, quo_nxt;
  logic        ge;

  assign ge = rem_r >= {1'b0, div_r};

  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    step_nxt   = step_r;
    mask_nxt   = mask_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    total_nxt  = total_r;
    acc_nxt    = acc_r;
    rem_nxt    = rem_r;
    div_nxt    = div_r;
    quo_nxt    = quo_r;
    unique case (phase_r)
      P_IDLE: begin
        if (req.start) begin
          mask_nxt   = req.mask;
          hour_nxt   = req.hour;
          minute_nxt = req.minute;
          idx_nxt    = 5'd0;
          total_nxt  = 11'd0;
          acc_nxt    = 11'd0;
          phase_nxt  = P_SCAN;
        end
      end
      P_SCAN: begin
        if (mask_r[idx_r]) begin
          total_nxt = total_r + 11'(MINUTES_PER_HOUR);
          if (hour_r > idx_r) begin
            acc_nxt = acc_r + 11'(MINUTES_PER_HOUR);
          end else if (hour_r == idx_r) begin
            acc_nxt = acc_r + 11'(minute_r);
          end
        end
        if (idx_r == 5'(HOURS_PER_DAY - 1)) begin
          phase_nxt = P_PREP;
        end else begin
          idx_nxt = idx_r + 5'd1;
        end
      end
      P_PREP: begin
        // done minutes times 100
        rem_nxt  = (18'(acc_r) << 6) + (18'(acc_r) << 5) + (18'(acc_r) << 2);
        div_nxt  = {total_r, 6'b0};
        quo_nxt  = 7'd0;
        step_nxt = 3'd6;
        phase_nxt = (total_r == 11'd0) ? P_DONE : P_DIV;
      end
      P_DIV: begin
        if (ge) begin
          rem_nxt = rem_r - {1'b0, div_r};
        end
        quo_nxt = {quo_r[5:0], ge};
        div_nxt = div_r >> 1;
        if (step_r == 3'd0) begin
          phase_nxt = P_DONE;
        end else begin
          step_nxt = step_r - 3'd1;
        end
      end
      P_DONE: begin
        phase_nxt = P_IDLE;
      end
      default: begin
        phase_nxt = P_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
    idx_r    <= idx_nxt;
    step_r   <= step_nxt;
    mask_r   <= mask_nxt;
    hour_r   <= hour_nxt;
    minute_r <= minute_nxt;
    total_r  <= total_nxt;
    acc_r    <= acc_nxt;
    rem_r    <= rem_nxt;
    div_r    <= div_nxt;
    quo_r    <= quo_nxt;
  end

  assign rsp.done = (phase_r == P_DONE);
  assign rsp.pct  = (quo_r > 7'd100) ? 7'd100 : quo_r;

endmodule

// ===== rtl/pump_schedule_controller.sv =====
// pump schedule controller top level: sequence state, mask choice, output register
// uses psc_pkg and psc_progress
//
// one request on the in_ channel is one control tick (clock, peak temperature,
// dosing busy flags). the pump command is updated at the edge the request is
// taken, and in auto mode the sequence and mask too. the progress unit then
// scans the 24 hour bits one per cycle, sets up the divide, divides one quotient
// bit per cycle (the divide is skipped when no hour bit is set) and hands the
// result to the output register. in_tready is low from the taken request until
// the result is loaded, so one request is done before the next is taken.
// the next request is taken as soon as the result sits in the output
// register, even while the receiver holds out_tready low; a stalled result holds
// its data and the block then waits before loading the next one.
// configuration is written through cfg_wr_en/cfg_addr/cfg_wdata; the user is to
// write it only while idle; the block does not enforce this. writing run_mode
// sends the sequence back to idle. reset clears state and configuration but not
// the output data; the sequence goes idle with the pump off, output channel empty.
module pump_schedule_controller #(
  parameter int WARMUP_TICKS       = 60,
  parameter int PERIODIC_RUN_TICKS = 30,
  parameter int FIRST_BAND_TEMP    = 150,
  parameter int BAND_STEP_TEMP     = 30,
  parameter int TEMP_BANDS         = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // hour_now, minute_now, peak_temp, ph_busy, orp_busy
  input  logic [psc_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // pump_run, seq_state, progress_pct, mask_in_use, mask_changed, zero fill
  output logic [psc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                               cfg_wr_en,
  input  logic [psc_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [psc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import psc_pkg::*;

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_BUSY = 2'd1;
  localparam logic [1:0] T_LOAD = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [1:0]  run_mode_r, run_mode_nxt;
  logic        auto_src_r, auto_src_nxt;
  logic [23:0] hour_prog_r, hour_prog_nxt;
  logic [23:0] tprog_r [4];
  logic [23:0] tprog_nxt [4];
  logic [15:0] interval_r, interval_nxt;
  logic [2:0]  seq_r, seq_nxt;
  logic        pump_r, pump_nxt;
  logic [15:0] cd_r, cd_nxt;
  logic [16:0] since_r, since_nxt;
  logic        once_r, once_nxt;
  logic [23:0] prior_mask_r, prior_mask_nxt;
  logic        changed_r, changed_nxt;
  logic        forced_r, forced_nxt;
  logic [6:0]  pct_r, pct_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_pump_r, out_pump_nxt;
  logic [2:0]  out_seq_r, out_seq_nxt;
  logic [6:0]  out_pct_r, out_pct_nxt;
  logic [23:0] out_mask_r, out_mask_nxt;
  logic        out_chg_r, out_chg_nxt;

  logic [4:0]         in_hour;
  logic [5:0]         in_minute;
  logic signed [10:0] in_temp;
  logic               in_busy;
  logic               in_acc;
  logic [1:0]         band;
  logic [23:0]        mask_sel;
  logic               hour_ok;
  logic [16:0]        since_inc;
  logic               cd_expire;
  prog_req_t          prog_req;
  prog_rsp_t          prog_rsp;

  assign in_hour   = in_tdata[4:0];
  assign in_minute = in_tdata[10:5];
  assign in_temp   = in_tdata[21:11];
  assign in_busy   = in_tdata[22] | in_tdata[23];
  assign in_tready = (state_r == T_IDLE);
  assign in_acc    = in_tvalid & in_tready;

  // band: count of band thresholds reached
  always_comb begin
    band = 2'd0;
    for (int k = 1; k < 4; k++) begin
      if (k < TEMP_BANDS && in_temp >= FIRST_BAND_TEMP + k * BAND_STEP_TEMP) begin
        band = band + 2'd1;
      end
    end
  end

  assign mask_sel  = auto_src_r ? tprog_r[band] : hour_prog_r;
  assign hour_ok   = (in_hour < 5'(HOURS_PER_DAY)) ? mask_sel[in_hour] : 1'b0;
  assign since_inc = (since_r < SINCE_MAX) ? since_r + 17'd1 : since_r;
  assign cd_expire = (cd_r <= 16'd1);

  assign prog_req.start  = in_acc;
  assign prog_req.mask   = mask_sel;
  assign prog_req.hour   = in_hour;
  assign prog_req.minute = in_minute;

  psc_progress u_progress (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (prog_req),
    .rsp   (prog_rsp)
  );

  // sequence and configuration
  always_comb begin
    run_mode_nxt   = run_mode_r;
    auto_src_nxt   = auto_src_r;
    hour_prog_nxt  = hour_prog_r;
    tprog_nxt      = tprog_r;
    interval_nxt   = interval_r;
    seq_nxt        = seq_r;
    pump_nxt       = pump_r;
    cd_nxt         = cd_r;
    since_nxt      = since_r;
    once_nxt       = once_r;
    prior_mask_nxt = prior_mask_r;
    changed_nxt    = changed_r;
    forced_nxt     = forced_r;
    if (in_acc) begin
      since_nxt   = since_inc;
      changed_nxt = 1'b0;
      forced_nxt  = (run_mode_r != RUN_AUTO);
      if (run_mode_r != RUN_AUTO) begin
        pump_nxt = (run_mode_r == RUN_ON);
      end else begin
        changed_nxt    = (mask_sel != prior_mask_r);
        prior_mask_nxt = mask_sel;
        unique case (seq_r)
          SEQ_IDLE: begin
            if (hour_ok) begin
              pump_nxt = 1'b1;
              cd_nxt   = 16'(WARMUP_TICKS);
              seq_nxt  = SEQ_WARMUP;
            end else if (!once_r ||
                         (interval_r != 16'd0 && since_inc >= {1'b0, interval_r})) begin
              since_nxt = 17'd0;
              once_nxt  = 1'b1;
              pump_nxt  = 1'b1;
              cd_nxt    = 16'(PERIODIC_RUN_TICKS);
              seq_nxt   = SEQ_PERIODIC;
            end
          end
          SEQ_PERIODIC: begin
            if (cd_expire) begin
              cd_nxt   = 16'd0;
              seq_nxt  = SEQ_IDLE;
              pump_nxt = 1'b0;
            end else begin
              cd_nxt = cd_r - 16'd1;
            end
          end
          SEQ_WARMUP: begin
            if (cd_expire) begin
              cd_nxt  = 16'd0;
              seq_nxt = SEQ_ACTIVE;
            end else begin
              cd_nxt = cd_r - 16'd1;
            end
          end
          SEQ_ACTIVE: begin
            if (!hour_ok) begin
              if (!in_busy) begin
                seq_nxt  = SEQ_IDLE;
                pump_nxt = 1'b0;
              end else begin
                seq_nxt = SEQ_EXTENDED;
              end
            end
          end
          SEQ_EXTENDED: begin
            if (!in_busy) begin
              seq_nxt  = SEQ_IDLE;
              pump_nxt = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
    end
    if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_RUN_MODE: begin
          run_mode_nxt = cfg_wdata[1:0];
          seq_nxt      = SEQ_IDLE;
          cd_nxt       = 16'd0;
          pump_nxt     = (cfg_wdata[1:0] == RUN_ON);
        end
        REG_AUTO_SRC:  auto_src_nxt  = cfg_wdata[0];
        REG_HOUR_PROG: hour_prog_nxt = cfg_wdata[23:0];
        REG_TPROG_0:   tprog_nxt[0]  = cfg_wdata[23:0];
        REG_TPROG_1:   tprog_nxt[1]  = cfg_wdata[23:0];
        REG_TPROG_2:   tprog_nxt[2]  = cfg_wdata[23:0];
        REG_TPROG_3:   tprog_nxt[3]  = cfg_wdata[23:0];
        REG_INTERVAL:  interval_nxt  = cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // request control and output register
  always_comb begin
    state_nxt     = state_r;
    pct_nxt       = pct_r;
    out_valid_nxt = out_valid_r;
    out_pump_nxt  = out_pump_r;
    out_seq_nxt   = out_seq_r;
    out_pct_nxt   = out_pct_r;
    out_mask_nxt  = out_mask_r;
    out_chg_nxt   = out_chg_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      T_IDLE: begin
        if (in_acc) begin
          state_nxt = T_BUSY;
        end
      end
      T_BUSY: begin
        if (prog_rsp.done) begin
          pct_nxt   = prog_rsp.pct;
          state_nxt = T_LOAD;
        end
      end
      T_LOAD: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_pump_nxt  = pump_r;
          out_seq_nxt   = seq_r;
          out_pct_nxt   = forced_r ? 7'd0 : pct_r;
          out_mask_nxt  = prior_mask_r;
          out_chg_nxt   = changed_r;
          state_nxt     = T_IDLE;
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= T_IDLE;
      run_mode_r   <= RUN_AUTO;
      auto_src_r   <= 1'b0;
      hour_prog_r  <= 24'd0;
      for (int i = 0; i < 4; i++) begin
        tprog_r[i] <= 24'd0;
      end
      interval_r   <= 16'd0;
      seq_r        <= SEQ_IDLE;
      pump_r       <= 1'b0;
      cd_r         <= 16'd0;
      since_r      <= 17'd0;
      once_r       <= 1'b0;
      prior_mask_r <= 24'd0;
      changed_r    <= 1'b0;
      forced_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      run_mode_r   <= run_mode_nxt;
      auto_src_r   <= auto_src_nxt;
      hour_prog_r  <= hour_prog_nxt;
      tprog_r      <= tprog_nxt;
      interval_r   <= interval_nxt;
      seq_r        <= seq_nxt;
      pump_r       <= pump_nxt;
      cd_r         <= cd_nxt;
      since_r      <= since_nxt;
      once_r       <= once_nxt;
      prior_mask_r <= prior_mask_nxt;
      changed_r    <= changed_nxt;
      forced_r     <= forced_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    pct_r      <= pct_nxt;
    out_pump_r <= out_pump_nxt;
    out_seq_r  <= out_seq_nxt;
    out_pct_r  <= out_pct_nxt;
    out_mask_r <= out_mask_nxt;
    out_chg_r  <= out_chg_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_chg_r, out_mask_r, out_pct_r, out_seq_r, out_pump_r};

endmodule

// ===== rtl/psc_checker.sv =====
// port-level checks of the pump schedule controller, bound to the top level
// uses psc_pkg and pump_schedule_controller_defines.svh
`include "pump_schedule_controller_defines.svh"

module psc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [psc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import psc_pkg::*;

  // stalled result keeps its data
  `PSC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // one request at a time
  `PSC_ASSERT_NEXT(a_busy_after_req, in_tvalid && in_tready, !in_tready)

  // progress never above a hundred percent
  `PSC_ASSERT_NOW(a_pct_range, out_tvalid, out_tdata[10:4] <= 7'd100)

  // every state but idle runs the pump
  `PSC_ASSERT_NOW(a_pump_on, out_tvalid && out_tdata[3:1] != SEQ_IDLE, out_tdata[0])

endmodule

bind pump_schedule_controller psc_checker u_psc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
